/* rtl/core/plt_pkg.sv */
// Shared types and constants for the pinned LRU frame table.
package plt_pkg;

    localparam logic [31:0] FREE_PAGE = 32'hFFFF_FFE9;
    localparam logic [31:0] CLOCK_MAX = 32'hFFFF_FFFF;

    typedef enum logic [2:0] {
        OP_LOOKUP = 3'd0,
        OP_FREE   = 3'd1,
        OP_VICTIM = 3'd2,
        OP_TOUCH  = 3'd3,
        OP_WRITE  = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RESP
    } state_t;

    typedef struct packed {
        logic [2:0]  op;
        logic [31:0] page;
        logic        match_file;
        logic [7:0]  tag;
    } scan_key_t;

    typedef struct packed {
        logic [31:0] page;
        logic [7:0]  file;
        logic [7:0]  pins;
        logic [31:0] stamp;
    } frame_entry_t;

    typedef struct packed {
        logic clear;
        logic eval;
    } scan_ctl_t;

endpackage

/* rtl/core/pinned_lru_frame_table_unit.sv */
// Top level of the pinned LRU frame table: sequencer, access clock and result registers.
//
//  channel  | signals                                              | handshake
//  ---------+------------------------------------------------------+----------------------
//  command  | op, page_id, match_file, file_tag, frame_index,      | start && !busy
//           | pin_value                                            |
//  result   | found, result_frame                                  | done, one cycle
//
// Touch, write and undefined ops: done in the cycle right after accept.
// Lookup, free and victim scans read one frame per cycle from the frame memory
// through a registered read port, and end early on a hit that stops the scan.
// busy rises after accept and stays high through the done cycle; the next word is taken after that.
// Reset clears the valid bits of every frame at once, so no clearing pass runs.
// Results are never stalled: done is high for exactly one cycle.
module pinned_lru_frame_table_unit #(
    parameter int FRAME_COUNT = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  op,
    input  logic [31:0] page_id,
    input  logic        match_file,
    input  logic [7:0]  file_tag,
    input  logic [3:0]  frame_index,
    input  logic [7:0]  pin_value,
    output logic        done,
    output logic        found,
    output logic [3:0]  result_frame
);
    import plt_pkg::*;

    localparam int AW = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
    localparam int IW = (AW > 4) ? AW : 4;

    state_t       state_reg;
    state_t       state_next;
    logic [AW:0]  ia_reg;
    logic [AW:0]  ia_next;
    logic         found_reg;
    logic         found_next;
    logic [3:0]   frame_reg;
    logic [3:0]   frame_next;
    logic [31:0]  clock_reg;
    logic [31:0]  clock_next;
    scan_key_t    key_reg;
    scan_key_t    key_next;

    logic          accept;
    logic          idx_ok;
    logic          scan_op;
    logic [IW-1:0] idx_ext;
    logic [AW-1:0] wr_addr;
    logic [31:0]   clock_inc;
    logic          meta_we;
    logic          stamp_we;
    logic          rd_en;
    logic          rd_valid;
    logic [AW-1:0] rd_idx;
    frame_entry_t  rd_entry;
    scan_ctl_t     scan_ctl;
    logic          scan_stop;
    logic          scan_hit;
    logic [AW-1:0] scan_pick;
    logic [IW-1:0] pick_ext;
    logic          scan_end;

    assign accept    = start && (state_reg == ST_IDLE);
    assign idx_ok    = (32'(frame_index) < 32'(FRAME_COUNT));
    assign scan_op   = (op == OP_LOOKUP) || (op == OP_FREE) || (op == OP_VICTIM);
    assign idx_ext   = IW'(frame_index);
    assign wr_addr   = idx_ext[AW-1:0];
    assign clock_inc = (clock_reg == CLOCK_MAX) ? clock_reg : clock_reg + 32'd1;
    assign pick_ext  = IW'(scan_pick);
    assign scan_end  = scan_ctl.eval && (scan_stop || rd_idx == AW'(FRAME_COUNT - 1));

    plt_frame_store #(
        .FRAME_COUNT(FRAME_COUNT),
        .AW(AW)
    ) u_store (
        .clk(clk),
        .rst_n(rst_n),
        .meta_we(meta_we),
        .stamp_we(stamp_we),
        .wr_addr(wr_addr),
        .wr_page(page_id),
        .wr_file(file_tag),
        .wr_pins(pin_value),
        .wr_stamp(clock_inc),
        .rd_en(rd_en),
        .rd_addr(ia_reg[AW-1:0]),
        .rd_valid(rd_valid),
        .rd_idx(rd_idx),
        .rd_entry(rd_entry)
    );

    plt_scan_unit #(
        .AW(AW)
    ) u_scan (
        .clk(clk),
        .rst_n(rst_n),
        .ctl(scan_ctl),
        .key(key_reg),
        .entry(rd_entry),
        .entry_idx(rd_idx),
        .stop(scan_stop),
        .hit(scan_hit),
        .pick(scan_pick)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = scan_op ? ST_SCAN : ST_RESP;
                end
            end
            ST_SCAN:
            begin
                if (scan_end)
                begin
                    state_next = ST_RESP;
                end
            end
            ST_RESP:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs and datapath control
    always_comb
    begin
        busy           = 1'b1;
        done           = 1'b0;
        meta_we        = 1'b0;
        stamp_we       = 1'b0;
        rd_en          = 1'b0;
        scan_ctl.clear = 1'b0;
        scan_ctl.eval  = 1'b0;
        ia_next        = ia_reg;
        key_next       = key_reg;
        found_next     = found_reg;
        frame_next     = frame_reg;
        clock_next     = clock_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
                if (accept)
                begin
                    key_next.op         = op;
                    key_next.page       = page_id;
                    key_next.match_file = match_file;
                    key_next.tag        = file_tag;
                    ia_next             = '0;
                    scan_ctl.clear      = 1'b1;
                    found_next          = 1'b0;
                    frame_next          = 4'd0;
                    if (idx_ok && (op == OP_TOUCH))
                    begin
                        stamp_we   = 1'b1;
                        clock_next = clock_inc;
                        found_next = 1'b1;
                        frame_next = frame_index;
                    end
                    if (idx_ok && (op == OP_WRITE))
                    begin
                        meta_we    = 1'b1;
                        found_next = 1'b1;
                        frame_next = frame_index;
                    end
                end
            end
            ST_SCAN:
            begin
                rd_en         = (ia_reg < (AW + 1)'(FRAME_COUNT));
                scan_ctl.eval = rd_valid;
                if (rd_en)
                begin
                    ia_next = ia_reg + (AW + 1)'(1);
                end
                if (scan_end)
                begin
                    found_next = scan_hit;
                    frame_next = scan_hit ? pick_ext[3:0] : 4'd0;
                end
            end
            ST_RESP:
            begin
                done = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ia_reg    <= '0;
            found_reg <= 1'b0;
            frame_reg <= 4'd0;
            clock_reg <= 32'd0;
        end
        else
        begin
            state_reg <= state_next;
            ia_reg    <= ia_next;
            found_reg <= found_next;
            frame_reg <= frame_next;
            clock_reg <= clock_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

    assign found        = found_reg;
    assign result_frame = frame_reg;

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held longer than one cycle");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accept");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !found) |-> (result_frame == 4'd0))
        else $error("miss result carries a nonzero frame");

    a_clock_mono: assert property (@(posedge clk) disable iff (!rst_n)
        ##1 (clock_reg >= $past(clock_reg)))
        else $error("access clock decreased");

endmodule

/* rtl/core/plt_frame_store.sv */
// Frame storage: metadata and stamp memories with per-entry valid bits.
module plt_frame_store #(
    parameter int FRAME_COUNT = 16,
    parameter int AW = 4
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  meta_we,
    input  logic                  stamp_we,
    input  logic [AW-1:0]         wr_addr,
    input  logic [31:0]           wr_page,
    input  logic [7:0]            wr_file,
    input  logic [7:0]            wr_pins,
    input  logic [31:0]           wr_stamp,
    input  logic                  rd_en,
    input  logic [AW-1:0]         rd_addr,
    output logic                  rd_valid,
    output logic [AW-1:0]         rd_idx,
    output plt_pkg::frame_entry_t rd_entry
);
    import plt_pkg::*;

    logic [47:0]            meta_mem [FRAME_COUNT];
    logic [31:0]            stamp_mem [FRAME_COUNT];
    logic [FRAME_COUNT-1:0] meta_vld_reg;
    logic [FRAME_COUNT-1:0] stamp_vld_reg;
    logic [47:0]            rd_meta_reg;
    logic [31:0]            rd_stamp_reg;
    logic                   rd_meta_vld_reg;
    logic                   rd_stamp_vld_reg;
    logic                   rd_valid_reg;
    logic [AW-1:0]          rd_idx_reg;

    always_ff @(posedge clk)
    begin
        if (meta_we)
        begin
            meta_mem[wr_addr] <= {wr_page, wr_file, wr_pins};
        end
        if (stamp_we)
        begin
            stamp_mem[wr_addr] <= wr_stamp;
        end
        if (rd_en)
        begin
            rd_meta_reg  <= meta_mem[rd_addr];
            rd_stamp_reg <= stamp_mem[rd_addr];
            rd_idx_reg   <= rd_addr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            meta_vld_reg     <= '0;
            stamp_vld_reg    <= '0;
            rd_meta_vld_reg  <= 1'b0;
            rd_stamp_vld_reg <= 1'b0;
            rd_valid_reg     <= 1'b0;
        end
        else
        begin
            if (meta_we)
            begin
                meta_vld_reg[wr_addr] <= 1'b1;
            end
            if (stamp_we)
            begin
                stamp_vld_reg[wr_addr] <= 1'b1;
            end
            rd_valid_reg <= rd_en;
            if (rd_en)
            begin
                rd_meta_vld_reg  <= meta_vld_reg[rd_addr];
                rd_stamp_vld_reg <= stamp_vld_reg[rd_addr];
            end
        end
    end

    assign rd_valid = rd_valid_reg;
    assign rd_idx   = rd_idx_reg;

    // unwritten entries read as the reset contents
    assign rd_entry.page  = rd_meta_vld_reg ? rd_meta_reg[47:16] : FREE_PAGE;
    assign rd_entry.file  = rd_meta_vld_reg ? rd_meta_reg[15:8] : 8'd0;
    assign rd_entry.pins  = rd_meta_vld_reg ? rd_meta_reg[7:0] : 8'd0;
    assign rd_entry.stamp = rd_stamp_vld_reg ? rd_stamp_reg : 32'd0;

endmodule

/* rtl/core/plt_scan_unit.sv */
// Shared compare unit: evaluates one frame per cycle for lookup, free and victim scans.
module plt_scan_unit #(
    parameter int AW = 4
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  plt_pkg::scan_ctl_t    ctl,
    input  plt_pkg::scan_key_t    key,
    input  plt_pkg::frame_entry_t entry,
    input  logic [AW-1:0]         entry_idx,
    output logic                  stop,
    output logic                  hit,
    output logic [AW-1:0]         pick
);
    import plt_pkg::*;

    logic          hit_reg;
    logic          hit_next;
    logic [AW-1:0] pick_reg;
    logic [AW-1:0] pick_next;
    logic [31:0]   best_reg;
    logic [31:0]   best_next;
    logic          is_free;
    logic          page_eq;
    logic          tag_ok;
    logic          older;

    assign is_free = (entry.page == FREE_PAGE);
    assign page_eq = (entry.page == key.page);
    assign tag_ok  = !key.match_file || (entry.file == key.tag);
    assign older   = (entry.stamp < best_reg);

    always_comb
    begin
        hit_next  = hit_reg;
        pick_next = pick_reg;
        best_next = best_reg;
        stop      = 1'b0;
        if (ctl.clear)
        begin
            hit_next  = 1'b0;
            pick_next = '0;
            best_next = '0;
        end
        else if (ctl.eval)
        begin
            unique case (key.op)
                OP_LOOKUP:
                begin
                    if (!is_free && page_eq && tag_ok)
                    begin
                        hit_next  = 1'b1;
                        pick_next = entry_idx;
                        stop      = 1'b1;
                    end
                end
                OP_FREE:
                begin
                    if (is_free)
                    begin
                        hit_next  = 1'b1;
                        pick_next = entry_idx;
                        stop      = 1'b1;
                    end
                end
                OP_VICTIM:
                begin
                    if (entry.pins == 8'd0)
                    begin
                        priority if (is_free)
                        begin
                            hit_next  = 1'b1;
                            pick_next = entry_idx;
                            stop      = 1'b1;
                        end
                        else if (!hit_reg || older)
                        begin
                            hit_next  = 1'b1;
                            pick_next = entry_idx;
                            best_next = entry.stamp;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg  <= 1'b0;
            pick_reg <= '0;
            best_reg <= '0;
        end
        else
        begin
            hit_reg  <= hit_next;
            pick_reg <= pick_next;
            best_reg <= best_next;
        end
    end

    assign hit  = hit_next;
    assign pick = pick_next;

endmodule
